FILE: rtl/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// types, character constants and byte classes for the markup byte tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package mbt_pkg;

    // token kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_IDENT = 2'd1;
    localparam logic [1:0] KIND_TEXT  = 2'd2;
    localparam logic [1:0] KIND_BREAK = 2'd3;

    // special bytes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // highest byte that can belong to an unquoted run
    localparam logic [7:0] RUN_BYTE_MAX = 8'd127;

    // output queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  code;
        logic [15:0] start_ofs;
        logic [15:0] end_ofs;
        logic [15:0] line;
        logic        last;
    } token_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        logic hit;
        hit = is_letter(b) || (b inside {[8'h30:8'h39]})
              || (b inside {8'h2E, 8'h3A, 8'h2F, 8'h5C, 8'h2C, 8'h5F, 8'h2D,
                            8'h3C, 8'h3E, 8'h27, 8'h21, 8'h3F, 8'h28, 8'h29});
        return hit && (b <= RUN_BYTE_MAX);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/markup_byte_tokenizer_core.sv
// ----------------------------------------------------------------------------
// markup_byte_tokenizer_core
// splits a markup byte stream into identifier, text, single-character and
// paragraph-break tokens with byte offsets and a line number
// ----------------------------------------------------------------------------
// path: input register, then the token queue, then the output
// throughput: one byte per cycle while two queue slots are free; a byte that
//   yields two tokens needs two output transfers, and the four-entry token
//   queue absorbs that while it drains
// reset: asynchronous, clears lexer state, offsets, line count and the queue;
//   no clearing pass, the block takes bytes as soon as reset is released
`default_nettype none

module markup_byte_tokenizer_core
    import mbt_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 16
)(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // byte channel
    input  wire logic        text_valid,
    output logic             text_ready,
    input  wire logic [7:0]  text_byte,
    input  wire logic        end_of_text,

    // token channel
    output logic             token_valid,
    input  wire logic        token_ready,
    output logic [1:0]       token_kind,
    output logic [7:0]       char_code,
    output logic [15:0]      start_offset,
    output logic [15:0]      end_offset,
    output logic [15:0]      line_number,
    output logic             last_of_group
);

    // lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_TEXT  = 3'd2,
        MODE_QUOTE = 3'd3,
        MODE_NL    = 3'd4,
        MODE_NL_CR = 3'd5
    } mode_t;

    typedef logic [OFFSET_BITS-1:0] ofs_t;

    // offsets are kept at OFFSET_BITS, tokens carry the low 16 bits
    function automatic token_t make_tok(input logic [1:0] kind, input logic [7:0] code,
                                        input ofs_t s, input ofs_t e,
                                        input logic [15:0] line);
        logic [31:0] s_w;
        logic [31:0] e_w;
        token_t      t;
        s_w         = 32'(s);
        e_w         = 32'(e);
        t.kind      = kind;
        t.code      = code;
        t.start_ofs = s_w[15:0];
        t.end_ofs   = e_w[15:0];
        t.line      = line;
        t.last      = 1'b0;
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // input register: holds one byte until the lexer can take it
    // ------------------------------------------------------------------------
    logic       in_full_reg, in_full_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // ------------------------------------------------------------------------
    // lexer state
    // ------------------------------------------------------------------------
    mode_t       mode_reg, mode_next;
    ofs_t        pos_reg, pos_next;           // offset of the current byte
    ofs_t        run_reg, run_next;           // start of pending run
    ofs_t        nl_reg, nl_next;             // offset of pending newline
    logic [15:0] line_reg, line_next;         // saturating newline count

    // ------------------------------------------------------------------------
    // token queue
    // ------------------------------------------------------------------------
    token_t                 queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;

    logic fire;      // lexer consumes the registered byte this cycle
    logic pop;       // output transfer this cycle

    // results of the registered byte
    token_t     tok0, tok1;
    logic [1:0] tok_cnt;

    // lexer takes a byte only when two queue slots are sure to be free
    assign fire       = in_full_reg && (count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2));
    assign text_ready = !in_full_reg || fire;
    assign pop        = token_valid && token_ready;

    // ------------------------------------------------------------------------
    // lexer step: run ending, idle handling and end-of-text flush, in order
    // ------------------------------------------------------------------------
    always_comb
    begin
        token_t t;
        logic   go_idle;
        logic   finish;
        ofs_t   fin_end;
        ofs_t   pos_inc;
        ofs_t   brk_end;

        mode_next = mode_reg;
        pos_next  = pos_reg;
        run_next  = run_reg;
        nl_next   = nl_reg;
        line_next = line_reg;
        tok0      = '0;
        tok1      = '0;
        tok_cnt   = 2'd0;
        t         = '0;
        go_idle   = 1'b0;
        finish    = 1'b0;
        fin_end   = pos_reg;
        pos_inc   = pos_reg + ofs_t'(1);
        brk_end   = nl_reg + ofs_t'(1);

        if (byte_reg == CH_NUL)
        begin
            // zero byte flushes the pending run at its own offset
            finish  = 1'b1;
            fin_end = pos_reg;
        end
        else
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (!is_letter(byte_reg))
                    begin
                        tok0    = make_tok(KIND_IDENT, 8'd0, run_reg, pos_reg, line_reg);
                        tok_cnt = 2'd1;
                        go_idle = 1'b1;
                    end
                end
                MODE_TEXT:
                begin
                    // spaces stay inside a text run
                    if (!(is_word(byte_reg) || byte_reg == CH_SPACE))
                    begin
                        tok0    = make_tok(KIND_TEXT, 8'd0, run_reg, pos_reg, line_reg);
                        tok_cnt = 2'd1;
                        go_idle = 1'b1;
                    end
                end
                MODE_QUOTE:
                begin
                    // newlines in quotes are part of the text and not counted
                    if (byte_reg == CH_QUOTE)
                    begin
                        tok0      = make_tok(KIND_TEXT, 8'd0, run_reg, pos_reg, line_reg);
                        tok_cnt   = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NL:
                begin
                    if (byte_reg == CH_LF)
                    begin
                        // break carries the count right after its first newline
                        tok0    = make_tok(KIND_BREAK, 8'd0, nl_reg, brk_end, line_reg);
                        tok_cnt = 2'd1;
                        go_idle = 1'b1;
                    end
                    else if (byte_reg == CH_CR)
                    begin
                        mode_next = MODE_NL_CR;
                    end
                    else
                    begin
                        go_idle = 1'b1;
                    end
                end
                MODE_NL_CR:
                begin
                    if (byte_reg == CH_LF)
                    begin
                        tok0    = make_tok(KIND_BREAK, 8'd0, nl_reg, brk_end, line_reg);
                        tok_cnt = 2'd1;
                    end
                    go_idle = 1'b1;
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase

            // byte handled as if the lexer were idle
            if (go_idle)
            begin
                mode_next = MODE_IDLE;
                if (byte_reg == CH_AT)
                begin
                    mode_next = MODE_IDENT;
                    run_next  = pos_reg;
                end
                else if (is_word(byte_reg))
                begin
                    mode_next = MODE_TEXT;
                    run_next  = pos_reg;
                end
                else if (byte_reg == CH_QUOTE)
                begin
                    mode_next = MODE_QUOTE;
                    run_next  = pos_inc;
                end
                else if (byte_reg == CH_SPACE || byte_reg == CH_CR)
                begin
                    // skipped
                end
                else if (byte_reg == CH_LF)
                begin
                    if (line_reg != 16'hFFFF)
                    begin
                        line_next = line_reg + 16'd1;
                    end
                    nl_next   = pos_reg;
                    mode_next = MODE_NL;
                end
                else
                begin
                    t = make_tok(KIND_CHAR, byte_reg, pos_reg, pos_inc, line_reg);
                    if (tok_cnt == 2'd0)
                    begin
                        tok0 = t;
                    end
                    else
                    begin
                        tok1 = t;
                    end
                    tok_cnt = tok_cnt + 2'd1;
                end
            end

            pos_next = pos_inc;
            if (last_reg)
            begin
                finish  = 1'b1;
                fin_end = pos_inc;
            end
        end

        // end of text or zero byte: flush pending run, then start over at offset 0, line 0
        if (finish)
        begin
            if (mode_next == MODE_IDENT || mode_next == MODE_TEXT
                || mode_next == MODE_QUOTE)
            begin
                t = make_tok((mode_next == MODE_IDENT) ? KIND_IDENT : KIND_TEXT, 8'd0,
                             run_next, fin_end, line_next);
                if (tok_cnt == 2'd0)
                begin
                    tok0 = t;
                end
                else
                begin
                    tok1 = t;
                end
                tok_cnt = tok_cnt + 2'd1;
            end
            pos_next  = '0;
            run_next  = '0;
            nl_next   = '0;
            line_next = '0;
            mode_next = MODE_IDLE;
        end

        // mark the final token of this byte
        if (tok_cnt == 2'd1)
        begin
            tok0.last = 1'b1;
        end
        else if (tok_cnt == 2'd2)
        begin
            tok1.last = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // control next values
    // ------------------------------------------------------------------------
    always_comb
    begin
        in_full_next = in_full_reg;
        if (text_valid && text_ready)
        begin
            in_full_next = 1'b1;
        end
        else if (fire)
        begin
            in_full_next = 1'b0;
        end

        wr_ptr_next = wr_ptr_reg;
        if (fire)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_BITS'(tok_cnt);
        end

        rd_ptr_next = rd_ptr_reg + QPTR_BITS'(pop);

        count_next = count_reg + (fire ? QCNT_BITS'(tok_cnt) : '0) - QCNT_BITS'(pop);
    end

    // ------------------------------------------------------------------------
    // control and lexer state registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            mode_reg    <= MODE_IDLE;
            pos_reg     <= '0;
            run_reg     <= '0;
            nl_reg      <= '0;
            line_reg    <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
            if (fire)
            begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
                run_reg  <= run_next;
                nl_reg   <= nl_next;
                line_reg <= line_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // payload registers: input byte and queue entries
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            byte_reg <= text_byte;
            last_reg <= end_of_text;
        end
        if (fire && tok_cnt != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= tok0;
        end
        if (fire && tok_cnt == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPTR_BITS'(1)] <= tok1;
        end
    end

    // ------------------------------------------------------------------------
    // output: head of the token queue
    // ------------------------------------------------------------------------
    assign token_valid   = (count_reg != '0);
    assign token_kind    = queue_reg[rd_ptr_reg].kind;
    assign char_code     = queue_reg[rd_ptr_reg].code;
    assign start_offset  = queue_reg[rd_ptr_reg].start_ofs;
    assign end_offset    = queue_reg[rd_ptr_reg].end_ofs;
    assign line_number   = queue_reg[rd_ptr_reg].line;
    assign last_of_group = queue_reg[rd_ptr_reg].last;

endmodule

`default_nettype wire
